// ===== rtl/pidc_pkg.sv =====
`timescale 1ns / 1ps

package pidc_pkg;

    localparam int DATA_WIDTH     = 16;
    localparam int GAIN_WIDTH     = 16;
    localparam int GAIN_FRAC_BITS = 8;

    // error and delta carry one extra bit so the subtraction cannot wrap
    localparam int DIFF_W     = DATA_WIDTH + 1;
    // gain is zero-extended to a signed operand of GAIN_WIDTH+1 bits
    localparam int PROD_W     = DIFF_W + GAIN_WIDTH + 1;
    localparam int SCALED_W   = PROD_W - GAIN_FRAC_BITS;
    // three-term sums before the clamp
    localparam int ACC_W      = SCALED_W + 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P          = 3'd0,
        REG_GAIN_I          = 3'd1,
        REG_GAIN_D          = 3'd2,
        REG_TARGET          = 3'd3,
        REG_LIMIT_LOW       = 3'd4,
        REG_LIMIT_HIGH      = 3'd5,
        REG_PROP_ON_MEASURE = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [GAIN_WIDTH-1:0] gain_p;
        logic [GAIN_WIDTH-1:0] gain_i;
        logic [GAIN_WIDTH-1:0] gain_d;
        logic [DATA_WIDTH-1:0] target;
        logic [DATA_WIDTH-1:0] limit_low;
        logic [DATA_WIDTH-1:0] limit_high;
        logic                  prop_on_measure;
    } cfg_t;

    localparam logic [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // upper limit tested first; crossed limits give hi above it, else lo
    function automatic logic [DATA_WIDTH-1:0] clamp_limits(
        input logic signed [ACC_W-1:0]      v,
        input logic signed [DATA_WIDTH-1:0] lo,
        input logic signed [DATA_WIDTH-1:0] hi
    );
        logic [DATA_WIDTH-1:0] r;
        if (v > ACC_W'(hi)) begin
            r = hi;
        end else if (v < ACC_W'(lo)) begin
            r = lo;
        end else begin
            r = v[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/pid_controller_step.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake             Payload
// s_        in   s_tvalid/s_tready     s_tdata  = measurement
// m_        out  m_tvalid/m_tready     m_tdata  = drive
// cfg_      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One sample per clock sustained while the m_ side accepts; each sample is held in
// the input register, then the result register, which drives m_tvalid. The three gain
// products and both clamps sit in the single stage between the two registers.
// Synchronous active-low reset clears the pipeline, the integral and previous
// measurement to zero and the registers to their defaults. A stalled m_ side
// holds the result register and backs up into the input register; cfg_ready is
// always high.

module pid_controller_step (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pidc_pkg::DATA_WIDTH-1:0]    s_tdata,   // [15:0] measurement
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pidc_pkg::DATA_WIDTH-1:0]    m_tdata,   // [15:0] drive
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pidc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pidc_pkg::*;

    cfg_t                  cfg_reg;
    logic                  in_valid_reg;
    logic [DATA_WIDTH-1:0] in_meas_reg;
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_drive_reg;
    logic [DATA_WIDTH-1:0] prev_meas_reg;
    logic [DATA_WIDTH-1:0] integral_sum_reg;
    logic [DATA_WIDTH-1:0] integral_sum_next;
    logic [DATA_WIDTH-1:0] drive_next;
    logic                  advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p          <= '0;
            cfg_reg.gain_i          <= '0;
            cfg_reg.gain_d          <= '0;
            cfg_reg.target          <= '0;
            cfg_reg.limit_low       <= DATA_MIN;
            cfg_reg.limit_high      <= DATA_MAX;
            cfg_reg.prop_on_measure <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GAIN_P:          cfg_reg.gain_p          <= cfg_data[GAIN_WIDTH-1:0];
                REG_GAIN_I:          cfg_reg.gain_i          <= cfg_data[GAIN_WIDTH-1:0];
                REG_GAIN_D:          cfg_reg.gain_d          <= cfg_data[GAIN_WIDTH-1:0];
                REG_TARGET:          cfg_reg.target          <= cfg_data[DATA_WIDTH-1:0];
                REG_LIMIT_LOW:       cfg_reg.limit_low       <= cfg_data[DATA_WIDTH-1:0];
                REG_LIMIT_HIGH:      cfg_reg.limit_high      <= cfg_data[DATA_WIDTH-1:0];
                REG_PROP_ON_MEASURE: cfg_reg.prop_on_measure <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // the stage fires when it holds a sample and the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_meas_reg <= s_tdata;
        end
    end

    pidc_core u_core (
        .cfg           (cfg_reg),
        .meas          (in_meas_reg),
        .prev_meas     (prev_meas_reg),
        .integral      (integral_sum_reg),
        .integral_next (integral_sum_next),
        .drive         (drive_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_meas_reg    <= '0;
            integral_sum_reg <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (advance) begin
                prev_meas_reg    <= in_meas_reg;
                integral_sum_reg <= integral_sum_next;
                out_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_drive_reg <= drive_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_drive_reg;

    // controller state only moves when a result is produced
    a_state_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(integral_sum_reg) && $stable(prev_meas_reg)))
        else $error("controller state changed while the result was stalled");

    a_state_hold_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |=> $stable(prev_meas_reg))
        else $error("previous measurement changed with no sample in the stage");

    a_stalled_sample_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid && !m_tready) |=> in_valid_reg)
        else $error("sample dropped from the input register during a stall");

    a_result_follows_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed sample produced no result");

endmodule

// ===== rtl/pidc_core.sv =====
`timescale 1ns / 1ps

module pidc_core (
    input  pidc_pkg::cfg_t                  cfg,
    input  logic [pidc_pkg::DATA_WIDTH-1:0] meas,
    input  logic [pidc_pkg::DATA_WIDTH-1:0] prev_meas,
    input  logic [pidc_pkg::DATA_WIDTH-1:0] integral,
    output logic [pidc_pkg::DATA_WIDTH-1:0] integral_next,
    output logic [pidc_pkg::DATA_WIDTH-1:0] drive
);
    import pidc_pkg::*;

    logic signed [DIFF_W-1:0]     err;
    logic signed [DIFF_W-1:0]     delta;
    logic signed [GAIN_WIDTH:0]   gp_s;
    logic signed [GAIN_WIDTH:0]   gi_s;
    logic signed [GAIN_WIDTH:0]   gd_s;
    logic signed [PROD_W-1:0]     prod_p;
    logic signed [PROD_W-1:0]     prod_i;
    logic signed [PROD_W-1:0]     prod_d;
    logic signed [SCALED_W-1:0]   sc_p;
    logic signed [SCALED_W-1:0]   sc_i;
    logic signed [SCALED_W-1:0]   sc_d;
    logic signed [ACC_W-1:0]      p_err_term;
    logic signed [ACC_W-1:0]      p_meas_term;
    logic signed [ACC_W-1:0]      sum_raw;
    logic signed [ACC_W-1:0]      drive_raw;
    logic signed [DATA_WIDTH-1:0] integral_s;
    logic signed [DATA_WIDTH-1:0] lo_s;
    logic signed [DATA_WIDTH-1:0] hi_s;

    assign lo_s       = $signed(cfg.limit_low);
    assign hi_s       = $signed(cfg.limit_high);
    assign integral_s = $signed(integral);

    assign err   = $signed({cfg.target[DATA_WIDTH-1], cfg.target})
                 - $signed({meas[DATA_WIDTH-1], meas});
    assign delta = $signed({meas[DATA_WIDTH-1], meas})
                 - $signed({prev_meas[DATA_WIDTH-1], prev_meas});

    assign gp_s = $signed({1'b0, cfg.gain_p});
    assign gi_s = $signed({1'b0, cfg.gain_i});
    assign gd_s = $signed({1'b0, cfg.gain_d});

    // p multiplies error or delta depending on mode; only one is needed
    assign prod_p = gp_s * (cfg.prop_on_measure ? delta : err);
    assign prod_i = gi_s * err;
    assign prod_d = gd_s * delta;

    // dropping the fraction bits is a floor shift on two's complement
    assign sc_p = $signed(prod_p[PROD_W-1:GAIN_FRAC_BITS]);
    assign sc_i = $signed(prod_i[PROD_W-1:GAIN_FRAC_BITS]);
    assign sc_d = $signed(prod_d[PROD_W-1:GAIN_FRAC_BITS]);

    assign p_err_term  = cfg.prop_on_measure ? ACC_W'(0) : ACC_W'(sc_p);
    assign p_meas_term = cfg.prop_on_measure ? ACC_W'(sc_p) : ACC_W'(0);

    assign sum_raw       = ACC_W'(integral_s) + ACC_W'(sc_i) - p_meas_term;
    assign integral_next = clamp_limits(sum_raw, lo_s, hi_s);

    assign drive_raw = p_err_term + ACC_W'($signed(integral_next)) - ACC_W'(sc_d);
    assign drive     = clamp_limits(drive_raw, lo_s, hi_s);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pidc_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RELOAD_EVERY = 60;
    // index outside the register map, writes to it must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DATA_WIDTH-1:0]  s_tdata = '0;     // [15:0] measurement
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [DATA_WIDTH-1:0]  m_tdata;          // [15:0] drive
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    pid_controller_step u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // controller shadow state
    logic        [GAIN_WIDTH-1:0] kp = '0;
    logic        [GAIN_WIDTH-1:0] ki = '0;
    logic        [GAIN_WIDTH-1:0] kd = '0;
    logic signed [DATA_WIDTH-1:0] setpoint = '0;
    logic signed [DATA_WIDTH-1:0] lim_lo = DATA_MIN;
    logic signed [DATA_WIDTH-1:0] lim_hi = DATA_MAX;
    logic                         pom_mode = 1'b0;
    logic signed [DATA_WIDTH-1:0] last_meas = '0;
    logic signed [DATA_WIDTH-1:0] integ = '0;

    logic [DATA_WIDTH-1:0] pending_drive[$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int mismatches    = 0;
    int samples_sent  = 0;
    int drives_seen   = 0;
    int reg_writes    = 0;

    function automatic longint gain_mult(input logic [GAIN_WIDTH-1:0] g, input longint x);
        longint gl;
        gl = g;
        return (gl * x) >>> GAIN_FRAC_BITS;
    endfunction

    // with crossed limits a value above lim_hi gives lim_hi, any other gives lim_lo
    function automatic longint clip(input longint v);
        if (v > longint'(lim_hi))
            return longint'(lim_hi);
        if (v < longint'(lim_lo))
            return longint'(lim_lo);
        return v;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] advance_pid(input logic signed [DATA_WIDTH-1:0] meas);
        longint err, delta, sum, drv;
        err   = longint'(setpoint) - longint'(meas);
        delta = longint'(meas) - longint'(last_meas);
        sum   = longint'(integ) + gain_mult(ki, err);
        if (pom_mode)
            sum -= gain_mult(kp, delta);
        sum   = clip(sum);
        integ = sum[DATA_WIDTH-1:0];
        drv   = pom_mode ? 0 : gain_mult(kp, err);
        drv   = clip(drv + sum - gain_mult(kd, delta));
        last_meas = meas;
        return drv[DATA_WIDTH-1:0];
    endfunction

    // --- drivers -------------------------------------------------------

    task automatic send_sample(input logic [DATA_WIDTH-1:0] meas);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= meas;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_drive.push_back(advance_pid(meas));
        samples_sent++;
    endtask

    // leaves cfg_valid high; cfg_release ends a group of writes
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_GAIN_P:          kp = val;
            REG_GAIN_I:          ki = val;
            REG_GAIN_D:          kd = val;
            REG_TARGET:          setpoint = val;
            REG_LIMIT_LOW:       lim_lo = val;
            REG_LIMIT_HIGH:      lim_hi = val;
            REG_PROP_ON_MEASURE: pom_mode = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
    endtask

    // always lets at least one edge pass, so whatever drives next starts in a new step
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending_drive.size() != 0);
    endtask

    task automatic load_all(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
                            input logic [15:0] tgt, input logic [15:0] lo,
                            input logic [15:0] hi, input logic [15:0] pom);
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        write_reg(REG_TARGET, tgt);
        write_reg(REG_LIMIT_LOW, lo);
        write_reg(REG_LIMIT_HIGH, hi);
        write_reg(REG_PROP_ON_MEASURE, pom);
        cfg_release();
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 512));
            4:       return 16'($urandom_range(0, 4095));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return DATA_MIN;
            1:       return DATA_MAX;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // --- receiver and checker -------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        logic [DATA_WIDTH-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            drives_seen++;
            if (pending_drive.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: drive %0d with no sample outstanding", $realtime,
                             $signed(m_tdata));
            end else begin
                want = pending_drive.pop_front();
                if (m_tdata !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: drive mismatch, expected %0d got %0d", $realtime,
                                 $signed(want), $signed(m_tdata));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb NOT OK");
            $finish;
        end
    end

    // --- tests ----------------------------------------------------------

    task automatic test_reset_defaults();
        // all gains zero after reset; first sample deltas against zero
        send_sample(DATA_MAX);
        send_sample(DATA_MIN);
        wait_drained();
    endtask

    task automatic test_directed();
        // full-scale gains against a full-scale error: both clamps hit
        load_all(16'hFFFF, 16'hFFFF, 16'hFFFF, DATA_MIN, DATA_MIN, DATA_MAX, 16'd0);
        send_sample(DATA_MAX);
        send_sample(DATA_MIN);
        send_sample(16'd0);
        wait_drained();
        // proportional on error inside narrow limits
        load_all(16'd256, 16'd16, 16'd128, 16'd1000, -16'sd500, 16'sd700, 16'd0);
        send_sample(16'd0);
        send_sample(16'd900);
        send_sample(16'd1100);
        send_sample(16'd1000);
        wait_drained();
        // proportional on measurement
        write_reg(REG_PROP_ON_MEASURE, 16'd1);
        cfg_release();
        send_sample(16'd1200);
        send_sample(16'd800);
        send_sample(16'd1000);
        wait_drained();
        // crossed limits: values above the upper one clamp to it, the rest to the lower one
        write_reg(REG_LIMIT_LOW, 16'sd300);
        write_reg(REG_LIMIT_HIGH, -16'sd300);
        cfg_release();
        send_sample(16'd0);
        send_sample(16'd1000);
        send_sample(-16'sd1000);
        wait_drained();
        // write to an unmapped index, then only bit 0 of the mode register counts
        write_reg(REG_UNUSED, 16'h1234);
        write_reg(REG_PROP_ON_MEASURE, 16'hFFFE);
        write_reg(REG_LIMIT_LOW, -16'sd2000);
        write_reg(REG_LIMIT_HIGH, 16'sd2000);
        cfg_release();
        send_sample(16'd500);
        send_sample(16'd0);
        wait_drained();
    endtask

    task automatic test_random(input int src_pct, input int sink_pct, input int n_items);
        logic [15:0] lo, hi, sw;
        int          v;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int n = 0; n < n_items; n++) begin
            if (n % RELOAD_EVERY == 0) begin
                wait_drained();
                case ($urandom_range(0, 9))
                    6: begin
                        lo = DATA_MIN;
                        hi = DATA_MAX;
                    end
                    7, 8, 9: begin
                        lo = pick_level();
                        hi = pick_level();
                    end
                    default: begin
                        lo = 16'(-$urandom_range(0, 20000));
                        hi = 16'($urandom_range(0, 20000));
                    end
                endcase
                // mostly ordered limits, sometimes left crossed
                if ($signed(lo) > $signed(hi) && $urandom_range(0, 2) != 0) begin
                    sw = lo;
                    lo = hi;
                    hi = sw;
                end
                if ($urandom_range(0, 7) == 0)
                    write_reg(REG_UNUSED, 16'($urandom));
                load_all(pick_gain(), pick_gain(), pick_gain(),
                         ($urandom_range(0, 3) == 0) ? pick_level() : 16'($urandom_range(0, 4000) - 2000),
                         lo, hi, 16'($urandom));
            end
            case ($urandom_range(0, 9))
                0: v = $signed(pick_level());
                1, 2: v = $signed(16'($urandom));
                default: begin
                    v = int'(setpoint) + $urandom_range(0, 4000) - 2000;
                    if (v > 32767) v = 32767;
                    if (v < -32768) v = -32768;
                end
            endcase
            send_sample(16'(v));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        load_all(16'd300, 16'd40, 16'd80, 16'd0, -16'sd8000, 16'sd8000, 16'd0);
        src_idle_pct = 0;
        hold_request = 300;
        for (int n = 0; n < 40; n++)
            send_sample(16'($urandom_range(0, 6000) - 3000));
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_directed();
        test_random(29, 55, 565);
        test_random(55, 29, 565);
        test_random(0, 0, 565);
        test_backpressure();

        s_tvalid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d samples sent, %0d drives checked, %0d register writes", samples_sent,
                 drives_seen, reg_writes);
        $display("both proportional modes, crossed and full-range limits, output back-pressure");
        if (mismatches == 0 && pending_drive.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("%0d mismatches, %0d drives missing", mismatches, pending_drive.size());
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
